// ----- sv/rgbhsl_pkg.sv -----
// Shared constants and types for the RGB to HSL converter.
package rgbhsl_pkg;
	localparam int CB = 8;
	localparam int FS = (1 << CB) - 1;
	localparam int QW = 12;
	localparam int RW = CB + 2 + QW;
	localparam int BW = CB + 3;
	localparam int NL = 2;
	localparam int HUE_WRAP = 3600;
	localparam int HUE_SCALE = 1200;
	localparam int FRAC_SCALE = 8190;
	localparam int FRAC_ONE = 4095;
	localparam int LW = CB + 13;
	localparam int LIT_SHIFT = 32;
	localparam int RCW = LIT_SHIFT - CB + 1;
	localparam int PW = LW + RCW;
	localparam longint LIT_RECIP = ((longint'(1) << LIT_SHIFT) + 2 * FS - 1) / (2 * FS);
	localparam logic [0:0] LANE_HUE = 1'd0;
	localparam logic [0:0] LANE_SAT = 1'd1;

	typedef struct packed {
		logic                        valid;
		logic                        hue_zero;
		logic                        sat_zero;
		logic [CB:0]                 sum;
		logic [NL-1:0][RW-1:0]       rem;
		logic [NL-1:0][RW-1:0]       dsh;
		logic [NL-1:0][QW-1:0]       quo;
	} cell_t;
endpackage

// ----- sv/rgbhsl_if.sv -----
// Channel interfaces for pixels in and HSL items out.
interface rgbhsl_pix_if;
	logic                      valid;
	logic                      ready;
	logic [rgbhsl_pkg::CB-1:0] red;
	logic [rgbhsl_pkg::CB-1:0] green;
	logic [rgbhsl_pkg::CB-1:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgbhsl_hsl_if;
	logic        valid;
	logic        ready;
	logic [11:0] hue;
	logic [11:0] saturation;
	logic [11:0] lightness;
	modport source (output valid, hue, saturation, lightness, input ready);
	modport sink (input valid, hue, saturation, lightness, output ready);
endinterface

// ----- sv/rgbhsl_front.sv -----
// Front stage: max, min, chroma, the lightness sum and the two dividend/divisor pairs.
module rgbhsl_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid,
	input  logic [rgbhsl_pkg::CB-1:0] red,
	input  logic [rgbhsl_pkg::CB-1:0] green,
	input  logic [rgbhsl_pkg::CB-1:0] blue,
	output rgbhsl_pkg::cell_t         cell_s1
);
	localparam int CB = rgbhsl_pkg::CB;
	localparam int RW = rgbhsl_pkg::RW;
	localparam int BW = rgbhsl_pkg::BW;

	logic [CB-1:0] hi, lo, c;
	logic [CB:0]   sum, den;
	logic [BW-1:0] base;
	logic [RW-1:0] hn, hd, sn, sd;
	rgbhsl_pkg::cell_t nxt;

	always_comb begin
		hi = red;
		if (green > hi) hi = green;
		if (blue > hi) hi = blue;
		lo = red;
		if (green < lo) lo = green;
		if (blue < lo) lo = blue;
		c = hi - lo;
		if (hi == red) begin
			if (green >= blue) base = BW'(green) - BW'(blue);
			else base = BW'(6) * BW'(c) - (BW'(blue) - BW'(green));
		end else if (hi == green) begin
			base = BW'(2) * BW'(c) + BW'(blue) - BW'(red);
		end else begin
			base = BW'(4) * BW'(c) + BW'(red) - BW'(green);
		end
		sum = (CB+1)'(hi) + (CB+1)'(lo);
		den = (sum <= (CB+1)'(rgbhsl_pkg::FS)) ? sum : ((CB+1)'(2 * rgbhsl_pkg::FS) - sum);
		hn = RW'(rgbhsl_pkg::HUE_SCALE) * RW'(base) + RW'(c);
		hd = RW'(c) << 1;
		sn = RW'(rgbhsl_pkg::FRAC_SCALE) * RW'(c) + RW'(den);
		sd = RW'(den) << 1;
		nxt.valid = valid;
		nxt.hue_zero = (c == '0);
		nxt.sat_zero = (den == '0);
		nxt.sum = sum;
		nxt.rem[rgbhsl_pkg::LANE_HUE] = hn;
		nxt.rem[rgbhsl_pkg::LANE_SAT] = sn;
		nxt.dsh[rgbhsl_pkg::LANE_HUE] = hd << (rgbhsl_pkg::QW - 1);
		nxt.dsh[rgbhsl_pkg::LANE_SAT] = sd << (rgbhsl_pkg::QW - 1);
		nxt.quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s1 <= '0;
		end else if (en) begin
			cell_s1 <= nxt;
		end
	end
endmodule

// ----- sv/rgbhsl_cell.sv -----
// Division cell: one quotient bit for each of the two lanes.
module rgbhsl_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rgbhsl_pkg::cell_t prev,
	output rgbhsl_pkg::cell_t cell_q
);
	rgbhsl_pkg::cell_t nxt;

	always_comb begin
		nxt = prev;
		for (int i = 0; i < rgbhsl_pkg::NL; i++) begin
			if (prev.rem[i] >= prev.dsh[i]) begin
				nxt.rem[i] = prev.rem[i] - prev.dsh[i];
				nxt.quo[i] = {prev.quo[i][rgbhsl_pkg::QW-2:0], 1'b1};
			end else begin
				nxt.quo[i] = {prev.quo[i][rgbhsl_pkg::QW-2:0], 1'b0};
			end
			nxt.dsh[i] = prev.dsh[i] >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (en) begin
			cell_q <= nxt;
		end
	end
endmodule

// ----- sv/rgb_to_hsl.sv -----
// Top level of the RGB to HSL pixel converter.
// Usage:
//   pixel: one item per pixel, 8-bit red, green and blue (255 is 1.0).
//   colour: one item per pixel, hue in tenths of a degree (0..3599),
//   saturation and lightness as 12-bit fractions (4095 is 1.0).
//   Both channels move an item when valid and ready are high at a clock edge.
// Timing:
//   The front stage registers the item at the accepting edge, twelve division
//   cells each settle one bit of the hue and saturation quotients, and the
//   output register forms lightness by a reciprocal multiplication of the
//   carried sum.
//   Throughput is one pixel per cycle while the output is not stalled.
// Stall:
//   While the receiver holds ready low with a result waiting, the whole row
//   holds and pixel.ready drops; nothing is lost or repeated.
// Reset:
//   arst_n clears all valid bits at once; no item is pending afterwards.
module rgb_to_hsl (
	input  logic clk,
	input  logic arst_n,
	rgbhsl_pix_if.sink   pixel,
	rgbhsl_hsl_if.source colour
);
	localparam int QW = rgbhsl_pkg::QW;
	localparam int LW = rgbhsl_pkg::LW;
	localparam int PW = rgbhsl_pkg::PW;

	logic              en;
	rgbhsl_pkg::cell_t chain [0:QW];
	logic [QW-1:0]     hq;
	logic [LW-1:0]     lit_num;
	logic [PW-1:0]     lit_prod;

	assign en = !colour.valid || colour.ready;
	assign pixel.ready = en;

	rgbhsl_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .valid(pixel.valid),
		.red(pixel.red), .green(pixel.green), .blue(pixel.blue),
		.cell_s1(chain[0])
	);

	for (genvar k = 0; k < QW; k++) begin : g_cell
		rgbhsl_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .prev(chain[k]), .cell_q(chain[k+1])
		);
	end

	assign hq = chain[QW].quo[rgbhsl_pkg::LANE_HUE];
	assign lit_num = LW'(rgbhsl_pkg::FRAC_ONE) * LW'(chain[QW].sum) + LW'(rgbhsl_pkg::FS);
	assign lit_prod = PW'(lit_num) * PW'(rgbhsl_pkg::LIT_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour.valid <= 1'b0;
			colour.hue <= '0;
			colour.saturation <= '0;
			colour.lightness <= '0;
		end else if (en) begin
			colour.valid <= chain[QW].valid;
			if (chain[QW].hue_zero) colour.hue <= '0;
			else if (hq >= QW'(rgbhsl_pkg::HUE_WRAP)) colour.hue <= hq - QW'(rgbhsl_pkg::HUE_WRAP);
			else colour.hue <= hq;
			colour.saturation <= chain[QW].sat_zero ? '0 : chain[QW].quo[rgbhsl_pkg::LANE_SAT];
			colour.lightness <= lit_prod[rgbhsl_pkg::LIT_SHIFT +: QW];
		end
	end

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		colour.valid |-> colour.hue < 12'd3600) else $error("hue out of range");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.ready == (!colour.valid || colour.ready)) else $error("ready mismatch");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(en && chain[QW].valid) |=> colour.valid) else $error("item dropped");
	a_grey_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(en && chain[QW].valid && chain[QW].hue_zero) |=> colour.saturation == '0)
		else $error("grey pixel with saturation");
`endif
endmodule

// ----- verif/tb_rgb_to_hsl.sv -----
// Testbench for the RGB to HSL pixel converter: directed and random pixels against an integer predictor.
`timescale 1ns / 1ps
module tb_rgb_to_hsl;
	typedef struct packed {
		logic [rgbhsl_pkg::CB-1:0] red;
		logic [rgbhsl_pkg::CB-1:0] green;
		logic [rgbhsl_pkg::CB-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [11:0] hue;
		logic [11:0] saturation;
		logic [11:0] lightness;
	} hsl_t;

	logic clk;
	logic arst_n;
	rgbhsl_pix_if pixel ();
	rgbhsl_hsl_if colour ();

	rgb_to_hsl dut (.clk(clk), .arst_n(arst_n), .pixel(pixel), .colour(colour));

	pixel_t pending_pixels[$];
	hsl_t   expected_colours[$];
	int     error_count;
	int     cycle_count;
	int     tx_gap;
	int     rx_gap;
	int     pixels_sent;
	int     colours_seen;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic hsl_t convert_pixel(pixel_t p);
		hsl_t     o;
		bit [63:0] r, g, b, hi, lo, c, base, hue, sum, den, sat, light;
		r = p.red;
		g = p.green;
		b = p.blue;
		hi = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		lo = r;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		c = hi - lo;
		hue = 0;
		if (c != 0) begin
			if (hi == r) begin
				if (g >= b) base = g - b;
				else base = 6 * c - (b - g);
			end else if (hi == g) begin
				base = 2 * c + b - r;
			end else begin
				base = 4 * c + r - g;
			end
			hue = (1200 * base + c) / (2 * c);
			if (hue >= 3600) hue -= 3600;
		end
		sum = hi + lo;
		light = (8190 * sum + 2 * rgbhsl_pkg::FS) / (4 * rgbhsl_pkg::FS);
		den = (sum <= rgbhsl_pkg::FS) ? sum : (2 * rgbhsl_pkg::FS - sum);
		sat = 0;
		if (den != 0) sat = (8190 * c + den) / (2 * den);
		o.hue = hue[11:0];
		o.saturation = sat[11:0];
		o.lightness = light[11:0];
		return o;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic pixel_t make_pixel(int r, int g, int b);
		pixel_t p;
		p.red = r[rgbhsl_pkg::CB-1:0];
		p.green = g[rgbhsl_pkg::CB-1:0];
		p.blue = b[rgbhsl_pkg::CB-1:0];
		return p;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel.valid <= 1'b0;
			pixel.red <= '0;
			pixel.green <= '0;
			pixel.blue <= '0;
			tx_gap <= 0;
		end else begin
			if (!pixel.valid || pixel.ready) begin
				if (pixel.valid) begin
					expected_colours.push_back(convert_pixel({pixel.red, pixel.green, pixel.blue}));
					pixels_sent <= pixels_sent + 1;
				end
				if (tx_gap > 0 || pending_pixels.size() == 0) begin
					pixel.valid <= 1'b0;
					if (tx_gap > 0) tx_gap <= tx_gap - 1;
				end else begin
					pixel_t p;
					p = pending_pixels.pop_front();
					pixel.valid <= 1'b1;
					pixel.red <= p.red;
					pixel.green <= p.green;
					pixel.blue <= p.blue;
					tx_gap <= (cycle_count % 700 < 200) ? 0 : pick_gap();
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour.ready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (colour.valid && colour.ready) begin
				hsl_t e;
				colours_seen <= colours_seen + 1;
				if (expected_colours.size() == 0) begin
					$error("unexpected item: hue %0d sat %0d light %0d",
						colour.hue, colour.saturation, colour.lightness);
					error_count <= error_count + 1;
				end else begin
					e = expected_colours.pop_front();
					if (e.hue !== colour.hue) begin
						$error("hue: expected %0d, got %0d", e.hue, colour.hue);
						error_count <= error_count + 1;
					end
					if (e.saturation !== colour.saturation) begin
						$error("saturation: expected %0d, got %0d",
							e.saturation, colour.saturation);
						error_count <= error_count + 1;
					end
					if (e.lightness !== colour.lightness) begin
						$error("lightness: expected %0d, got %0d",
							e.lightness, colour.lightness);
						error_count <= error_count + 1;
					end
				end
			end
			if (rx_gap > 0) begin
				colour.ready <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else begin
				colour.ready <= 1'b1;
				if (cycle_count % 900 >= 300 && $urandom_range(0, 3) == 0) rx_gap <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 500000) begin
			$display("tb_rgb_to_hsl: FAIL");
			$finish;
		end
	end

	initial begin
		int quiet;
		arst_n = 1'b0;
		// directed corners: greys, primaries, ties, red sextant wrap, near-black/white
		pending_pixels.push_back(make_pixel(0, 0, 0));
		pending_pixels.push_back(make_pixel(255, 255, 255));
		pending_pixels.push_back(make_pixel(128, 128, 128));
		pending_pixels.push_back(make_pixel(255, 0, 0));
		pending_pixels.push_back(make_pixel(0, 255, 0));
		pending_pixels.push_back(make_pixel(0, 0, 255));
		pending_pixels.push_back(make_pixel(255, 255, 0));
		pending_pixels.push_back(make_pixel(0, 255, 255));
		pending_pixels.push_back(make_pixel(255, 0, 255));
		pending_pixels.push_back(make_pixel(255, 0, 1));
		pending_pixels.push_back(make_pixel(255, 254, 255));
		pending_pixels.push_back(make_pixel(200, 100, 101));
		pending_pixels.push_back(make_pixel(1, 0, 0));
		pending_pixels.push_back(make_pixel(0, 1, 1));
		pending_pixels.push_back(make_pixel(255, 254, 254));
		pending_pixels.push_back(make_pixel(254, 255, 255));
		pending_pixels.push_back(make_pixel(170, 85, 0));
		pending_pixels.push_back(make_pixel(85, 170, 255));
		pending_pixels.push_back(make_pixel(127, 128, 0));
		pending_pixels.push_back(make_pixel(100, 100, 50));
		for (int i = 0; i < 1400; i++) begin
			int k;
			k = $urandom_range(0, 9);
			if (k < 6) begin
				pending_pixels.push_back(make_pixel($urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255)));
			end else if (k < 8) begin
				int a;
				a = $urandom_range(0, 255);
				pending_pixels.push_back(make_pixel(a, ($urandom_range(0, 1) ? a :
					$urandom_range(0, 255)), $urandom_range(0, 255)));
			end else begin
				int base;
				base = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(251, 255);
				pending_pixels.push_back(make_pixel(base, base + $urandom_range(0, 1) * 1,
					base - $urandom_range(0, 1)));
			end
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_pixels.size() == 0 && !pixel.valid);
		wait (expected_colours.size() == 0);
		quiet = 0;
		while (quiet < 40) begin
			@(posedge clk);
			quiet++;
		end
		$display("Converted %0d pixels, checked %0d HSL items under random stalls on both sides.",
			pixels_sent, colours_seen);
		if (error_count == 0 && expected_colours.size() == 0) begin
			$display("tb_rgb_to_hsl: PASS");
		end else begin
			$display("tb_rgb_to_hsl: FAIL");
		end
		$finish;
	end
endmodule

// ----- files.f -----
sv/rgbhsl_pkg.sv
sv/rgbhsl_if.sv
sv/rgbhsl_front.sv
sv/rgbhsl_cell.sv
sv/rgb_to_hsl.sv
verif/tb_rgb_to_hsl.sv
